// File: rtl/text_console_cursor_control_unit_macros.svh
// Assertion helpers shared by the console blocks.
// Every check runs on i_clk and is disabled while i_rst_n is low.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication
`define TCCU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("console check failed");

// Next-cycle implication
`define TCCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("console check failed");

`endif

// File: rtl/tccu_pkg.sv
`timescale 1ns / 1ps

package tccu_pkg;

    // Font geometry
    localparam int GLYPH_WIDTH  = 6;
    localparam int GLYPH_HEIGHT = 8;

    // Largest number of commands one byte can cause
    localparam int MAX_CMDS = 3;

    // Character codes
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_CR         = 8'h0D;
    localparam logic [7:0] CHAR_LF         = 8'h0A;

    // Configuration reset values
    localparam logic [1:0] OVERFLOW_MODE_RESET = 2'd0;
    localparam logic [7:0] DISPLAY_WIDTH_RESET = 8'd128;
    localparam logic [3:0] TEXT_LINES_RESET    = 4'd8;

    // Display limits
    localparam logic [7:0] DISPLAY_WIDTH_MAX = 8'd128;
    localparam logic [3:0] TEXT_LINES_MIN    = 4'd1;
    localparam logic [3:0] TEXT_LINES_MAX    = 4'd8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_OVERFLOW_MODE = 2'd0,
        CFG_DISPLAY_WIDTH = 2'd1,
        CFG_TEXT_LINES    = 2'd2
    } t_cfg_idx;

    // Overflow modes
    typedef enum logic [1:0] {
        MODE_OVERRIDE = 2'd0,
        MODE_SCROLL   = 2'd1,
        MODE_CLEAR    = 2'd2
    } t_mode;

    // Display command kinds
    typedef enum logic [1:0] {
        KIND_DRAW         = 2'd0,
        KIND_CLEAR_ROW    = 2'd1,
        KIND_START_LINE   = 2'd2,
        KIND_CLEAR_SCREEN = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] pixel_column;
        logic [2:0] text_row;
        logic [7:0] glyph_code;
        logic [5:0] start_line;
    } t_cmd;

    // All commands of one byte, slot 0 goes out first
    typedef struct packed {
        t_cmd [MAX_CMDS-1:0] cmds;
        logic [1:0]          count;
    } t_plan;

endpackage

// File: rtl/tccu_front.sv
`timescale 1ns / 1ps

module tccu_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_char_code,
    input  logic                i_queue_full,
    output logic                o_push,
    output tccu_pkg::t_plan     o_plan
);

    localparam logic [7:0] GW8 = 8'(tccu_pkg::GLYPH_WIDTH);

    // Configuration and cursor state
    logic [1:0] r_overflow_mode;
    logic [7:0] r_display_width;
    logic [3:0] r_text_lines;
    logic [7:0] r_col;
    logic [3:0] r_line;
    logic       r_lf_pending;

    logic [7:0] n_col;
    logic [4:0] n_line;

    logic       accept;
    logic       is_cr;
    logic       is_lf;
    logic       eol;
    logic [7:0] w_eff;
    logic [3:0] h_eff;
    logic [4:0] h5;
    logic [4:0] line_inc;
    logic [4:0] scroll_k;
    logic [9:0] start_prod;
    logic [4:0] draw_row;
    logic [1:0] n_cmds;
    tccu_pkg::t_plan plan;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign is_cr      = (i_char_code == tccu_pkg::CHAR_CR);
    assign is_lf      = (i_char_code == tccu_pkg::CHAR_LF);

    // Clamp the display geometry
    always_comb begin
        if (r_display_width < GW8) begin
            w_eff = GW8;
        end else if (r_display_width > tccu_pkg::DISPLAY_WIDTH_MAX) begin
            w_eff = tccu_pkg::DISPLAY_WIDTH_MAX;
        end else begin
            w_eff = r_display_width;
        end
        if (r_text_lines < tccu_pkg::TEXT_LINES_MIN) begin
            h_eff = tccu_pkg::TEXT_LINES_MIN;
        end else if (r_text_lines > tccu_pkg::TEXT_LINES_MAX) begin
            h_eff = tccu_pkg::TEXT_LINES_MAX;
        end else begin
            h_eff = r_text_lines;
        end
    end

    assign h5       = {1'b0, h_eff};
    assign eol      = r_col > (w_eff - GW8);
    assign line_inc = {1'b0, r_line} + 5'd1;

    // Classify the byte and build its command list
    always_comb begin
        plan       = '0;
        n_cmds     = 2'd0;
        n_col      = (eol || is_cr) ? 8'd0 : r_col;
        n_line     = {1'b0, r_line};
        scroll_k   = 5'd0;
        start_prod = 10'd0;
        draw_row   = 5'd0;

        if (eol || r_lf_pending) begin
            n_line = line_inc;
            if (line_inc >= h5) begin
                unique case (r_overflow_mode)
                    tccu_pkg::MODE_SCROLL: begin
                        if (line_inc >= {h_eff, 1'b0}) begin
                            n_line = h5;
                        end
                        scroll_k   = n_line - h5 + 5'd1;
                        start_prod = 10'(scroll_k) * 10'(tccu_pkg::GLYPH_HEIGHT);
                        plan.cmds[0].kind       = tccu_pkg::KIND_START_LINE;
                        plan.cmds[0].start_line = start_prod[5:0];
                        plan.cmds[1].kind       = tccu_pkg::KIND_CLEAR_ROW;
                        plan.cmds[1].text_row   = 3'(n_line - h5);
                        n_cmds = 2'd2;
                    end
                    tccu_pkg::MODE_CLEAR: begin
                        plan.cmds[0].kind = tccu_pkg::KIND_CLEAR_SCREEN;
                        plan.cmds[1].kind = tccu_pkg::KIND_START_LINE;
                        n_cmds = 2'd2;
                        n_col  = 8'd0;
                        n_line = 5'd0;
                    end
                    default: begin
                        // override, and the unused mode code
                        n_line = h5 - 5'd1;
                        plan.cmds[0].kind     = tccu_pkg::KIND_CLEAR_ROW;
                        plan.cmds[0].text_row = 3'(n_line);
                        n_cmds = 2'd1;
                    end
                endcase
            end
        end

        // Draw printable and control bytes, not CR or LF
        if (!(is_cr || is_lf)) begin
            draw_row = (n_line < h5) ? n_line : (n_line - h5);
            plan.cmds[n_cmds].kind         = tccu_pkg::KIND_DRAW;
            plan.cmds[n_cmds].pixel_column = n_col[6:0];
            plan.cmds[n_cmds].text_row     = draw_row[2:0];
            plan.cmds[n_cmds].glyph_code   = (i_char_code < tccu_pkg::CHAR_SPACE) ?
                                             tccu_pkg::CHAR_UNDERSCORE : i_char_code;
            n_cmds = n_cmds + 2'd1;
            n_col  = n_col + GW8;
        end
        plan.count = n_cmds;
    end

    assign o_plan = plan;
    assign o_push = accept && (n_cmds != 2'd0);

    // Configuration writes and cursor update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overflow_mode <= tccu_pkg::OVERFLOW_MODE_RESET;
            r_display_width <= tccu_pkg::DISPLAY_WIDTH_RESET;
            r_text_lines    <= tccu_pkg::TEXT_LINES_RESET;
            r_col           <= 8'd0;
            r_line          <= 4'd0;
            r_lf_pending    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    tccu_pkg::CFG_OVERFLOW_MODE: r_overflow_mode <= i_cfg_wdata[1:0];
                    tccu_pkg::CFG_DISPLAY_WIDTH: r_display_width <= i_cfg_wdata;
                    tccu_pkg::CFG_TEXT_LINES:    r_text_lines    <= i_cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_col        <= n_col;
                r_line       <= n_line[3:0];
                r_lf_pending <= is_lf;
            end
        end
    end

endmodule

// File: rtl/tccu_queue.sv
`timescale 1ns / 1ps
`include "text_console_cursor_control_unit_macros.svh"

module tccu_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tccu_pkg::t_plan i_plan,
    input  logic            i_pop,
    output tccu_pkg::t_plan o_plan,
    output logic            o_full,
    output logic            o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    tccu_pkg::t_plan  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_plan  = r_mem[r_rd_ptr];

    // Plan storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `TCCU_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_FULL)
    `TCCU_ASSERT_SAME(a_no_push_full, i_push, !o_full)
    `TCCU_ASSERT_SAME(a_no_pop_empty, i_pop, !o_empty)

endmodule

// File: rtl/tccu_back.sv
`timescale 1ns / 1ps
`include "text_console_cursor_control_unit_macros.svh"

module tccu_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tccu_pkg::t_plan i_plan,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [1:0]      o_command_kind,
    output logic [6:0]      o_pixel_column,
    output logic [2:0]      o_text_row,
    output logic [7:0]      o_glyph_code,
    output logic [5:0]      o_start_line,
    output logic            o_last_command
);

    tccu_pkg::t_plan r_plan;
    logic [1:0]      r_idx;
    logic            r_busy;

    logic            out_fire;
    logic            last;
    tccu_pkg::t_cmd  cur;

    assign cur      = r_plan.cmds[r_idx];
    assign last     = (r_idx == (r_plan.count - 2'd1));
    assign out_fire = r_busy && i_out_ready;

    // Take the next plan when idle or when the final command leaves
    assign o_pop = !i_empty && (!r_busy || (out_fire && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_pop) begin
            r_plan <= i_plan;
            r_idx  <= 2'd0;
            r_busy <= 1'b1;
        end else if (out_fire) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    assign o_out_valid    = r_busy;
    assign o_command_kind = cur.kind;
    assign o_pixel_column = cur.pixel_column;
    assign o_text_row     = cur.text_row;
    assign o_glyph_code   = cur.glyph_code;
    assign o_start_line   = cur.start_line;
    assign o_last_command = last;

    `TCCU_ASSERT_SAME(a_busy_count, r_busy, r_plan.count != 2'd0)
    `TCCU_ASSERT_SAME(a_idx_in_plan, r_busy, r_idx < r_plan.count)
    `TCCU_ASSERT_NEXT(a_stall_holds, r_busy && !i_out_ready, r_busy && $stable(r_idx))

endmodule

// File: rtl/text_console_cursor_control_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_char_code
// output    out        o_out_valid / i_out_ready  o_command_kind, o_pixel_column,
//                                                 o_text_row, o_glyph_code,
//                                                 o_start_line, o_last_command
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// The front takes one byte per cycle while the plan queue has room; the back
// sends one command per cycle while i_out_ready is high, so a byte takes as
// many output transfers as it has commands (0 to 3, set by the front's plan).
// A byte's first command is written into the plan queue and then loaded into
// the back's plan register before o_out_valid shows it.
// Synchronous active-low reset clears cursor, loads register defaults, empties
// the queue. A stalled output fills the queue and then drops o_in_ready.

module text_console_cursor_control_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_command_kind,
    output logic [6:0] o_pixel_column,
    output logic [2:0] o_text_row,
    output logic [7:0] o_glyph_code,
    output logic [5:0] o_start_line,
    output logic       o_last_command
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    tccu_pkg::t_plan front_plan;
    tccu_pkg::t_plan head_plan;

    tccu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_queue_full (full),
        .o_push       (push),
        .o_plan       (front_plan)
    );

    tccu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (front_plan),
        .i_pop   (pop),
        .o_plan  (head_plan),
        .o_full  (full),
        .o_empty (empty)
    );

    tccu_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_plan         (head_plan),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_command_kind (o_command_kind),
        .o_pixel_column (o_pixel_column),
        .o_text_row     (o_text_row),
        .o_glyph_code   (o_glyph_code),
        .o_start_line   (o_start_line),
        .o_last_command (o_last_command)
    );

endmodule
